// ----- design/assert_macros.svh -----
// Assertion shorthands for the RTL. The including module must have clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ----- design/htu_pkg.sv -----
`default_nettype none

package htu_pkg;

  localparam int MAX_SIDE_DEF = 64;
  localparam int STEP_DEF     = 5;
  localparam int SIDE_W       = 7;
  localparam int SIDE_RESET   = 41;
  localparam int COORD_W      = 9;
  localparam int SAMPLE_W     = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_RANGE = 1'b1;

  typedef struct packed {
    logic                       opcode;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         col;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] height;
    logic                       status;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_DRAIN,
    ST_RND_GO,
    ST_RND_WAIT,
    ST_OUT
  } state_t;

  // Corners of one triangle, read in this order.
  typedef enum logic [1:0] {
    CRN_MAIN,
    CRN_RIGHT,
    CRN_DOWN
  } corner_t;

endpackage

`default_nettype wire

// ----- design/heightmap_triangle_upsampler.sv -----
// Triangle upsampler over a coarse height grid.
// Input channel in_valid/in_ready/in_data carries one word per item. A write word stores
// a signed Q8.8 sample at coarse (row, col); a query word names a fine-grid point and
// yields one result word on out_valid/out_ready/out_data. Writes yield nothing.
// Channel cfg_valid/cfg_ready/cfg_data sets the coarse side in use and is always ready;
// the user must write it only while the block has no work in flight; it is not checked.
// A write goes straight into the grid memory. A query inside the fine grid first has its
// coordinates split by STEP, then uses the single grid memory read port once per triangle
// corner (the read for a corner of weight zero is skipped), then drains the accumulator
// and waits on the rounding divider before its result enters the output register. A query
// outside the fine grid goes straight to output and returns status 1 with height 0.
// Only one item is worked on at a time. The result sits in an output register, so the
// next item is accepted while it waits; a query that finishes while the previous result
// is still stalled waits until the register frees.
// Reset sets the side to 41 and empties the pipeline; the grid memory is not cleared and
// must be written before it is read.
`default_nettype none
`include "assert_macros.svh"

module heightmap_triangle_upsampler #(
  parameter int MAX_SIDE = htu_pkg::MAX_SIDE_DEF,
  parameter int STEP     = htu_pkg::STEP_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire htu_pkg::in_word_t           in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output htu_pkg::out_word_t               out_data,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [htu_pkg::SIDE_W-1:0]  cfg_data
);

  import htu_pkg::*;

  localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int IW     = $clog2(MAX_SIDE);
  localparam int OW     = $clog2(STEP);
  localparam int WW     = $clog2(STEP + 1);
  localparam int SUM_W  = SAMPLE_W + 1 + WW;
  localparam int FINE_W = $clog2((MAX_SIDE - 1) * STEP + 2);
  localparam int SCW    = $clog2(MAX_SIDE + 1);

  function automatic logic [FINE_W-1:0] fine_of(input logic [SIDE_W-1:0] s);
    logic [SCW-1:0] sc;
    if (int'(s) < 2) begin
      sc = SCW'(2);
    end else if (int'(s) > MAX_SIDE) begin
      sc = SCW'(MAX_SIDE);
    end else begin
      sc = SCW'(s);
    end
    return FINE_W'((int'(sc) - 1) * STEP + 1);
  endfunction

  state_t  state_r, state_nxt;
  corner_t k_r, k_nxt;
  logic    status_r, status_nxt;

  logic [SIDE_W-1:0] side_r, side_nxt;
  logic [FINE_W-1:0] fine_r;

  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic                    pend_r;
  logic [WW-1:0]           w_r;

  out_word_t out_r;
  logic      out_valid_r, out_valid_nxt;

  logic acc, is_query, oor, ram_we, rd_en, rnd_load, rnd_done, out_load, clr_sum;
  logic [AW-1:0]       waddr, raddr;
  logic [SAMPLE_W-1:0] rdata, rnd_height;

  logic [COORD_W-1:0] gx, gy;
  logic [OW-1:0]      ox, oy;
  logic [IW-1:0]      rr, cc;
  logic [WW-1:0]      wt;
  logic [WW:0]        oxy;
  logic               upper;

  // Configuration and the derived fine-grid size.
  assign cfg_ready = 1'b1;
  assign side_nxt  = (cfg_valid && cfg_ready) ? cfg_data : side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= SIDE_W'(SIDE_RESET);
      fine_r <= fine_of(SIDE_W'(SIDE_RESET));
    end else begin
      side_r <= side_nxt;
      fine_r <= fine_of(side_nxt);
    end
  end

  // Input side.
  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;
  assign is_query = (in_data.opcode == OP_QUERY);
  assign oor      = (int'(in_data.row) >= int'(fine_r)) || (int'(in_data.col) >= int'(fine_r));
  assign ram_we   = acc && !is_query && (int'(in_data.row) < MAX_SIDE)
                    && (int'(in_data.col) < MAX_SIDE);
  assign waddr    = AW'(int'(in_data.row[IW-1:0]) * MAX_SIDE + int'(in_data.col[IW-1:0]));

  htu_coord #(.STEP(STEP)) u_coord (
    .clk  (clk),
    .load (acc && is_query),
    .row  (in_data.row),
    .col  (in_data.col),
    .gx   (gx),
    .gy   (gy),
    .ox   (ox),
    .oy   (oy)
  );

  // Corner selection. The cell is cut along its anti-diagonal; the upper triangle
  // hangs off the top-left corner and the lower one off the bottom-right corner.
  assign oxy   = (WW+1)'(ox) + (WW+1)'(oy);
  assign upper = (int'(oxy) <= STEP);

  always_comb begin
    case (k_r)
      CRN_MAIN: begin
        if (upper) begin
          rr = IW'(gx);
          cc = IW'(gy);
          wt = WW'(STEP - int'(oxy));
        end else begin
          rr = IW'(gx) + IW'(1);
          cc = IW'(gy) + IW'(1);
          wt = WW'(int'(oxy) - STEP);
        end
      end
      CRN_RIGHT: begin
        rr = IW'(gx) + IW'(1);
        cc = IW'(gy);
        wt = upper ? WW'(ox) : WW'(STEP - int'(oy));
      end
      CRN_DOWN: begin
        rr = IW'(gx);
        cc = IW'(gy) + IW'(1);
        wt = upper ? WW'(oy) : WW'(STEP - int'(ox));
      end
      default: begin
        rr = '0;
        cc = '0;
        wt = '0;
      end
    endcase
  end

  assign rd_en = (state_r == ST_READ) && (wt != '0);
  assign raddr = AW'(int'(rr) * MAX_SIDE + int'(cc));

  htu_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (in_data.sample),
    .re    (rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Weighted sum; each read word is folded in the cycle after its address.
  always_comb begin
    if (clr_sum) begin
      sum_nxt = '0;
    end else if (pend_r) begin
      sum_nxt = sum_r + ($signed(rdata) * $signed({1'b0, w_r}));
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    w_r   <= wt;
  end

  htu_round #(.STEP(STEP)) u_round (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (rnd_load),
    .sum    (sum_r),
    .done   (rnd_done),
    .height (rnd_height)
  );

  // Control.
  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    status_nxt = status_r;
    rnd_load   = 1'b0;
    out_load   = 1'b0;
    clr_sum    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (acc && is_query) begin
          status_nxt = oor ? STAT_RANGE : STAT_OK;
          state_nxt  = oor ? ST_OUT : ST_DIV;
        end
      end
      ST_DIV: begin
        clr_sum   = 1'b1;
        k_nxt     = CRN_MAIN;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        case (k_r)
          CRN_MAIN:  k_nxt = CRN_RIGHT;
          CRN_RIGHT: k_nxt = CRN_DOWN;
          default:   state_nxt = ST_DRAIN;
        endcase
      end
      ST_DRAIN: begin
        state_nxt = ST_RND_GO;
      end
      ST_RND_GO: begin
        rnd_load  = 1'b1;
        state_nxt = ST_RND_WAIT;
      end
      ST_RND_WAIT: begin
        if (rnd_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= CRN_MAIN;
      status_r    <= STAT_OK;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      status_r    <= status_nxt;
      pend_r      <= rd_en;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.status <= status_r;
      out_r.height <= (status_r == STAT_RANGE) ? '0 : $signed(rnd_height);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_NEVER(a_grid_port_clash, ram_we && rd_en, "grid write and read in one cycle")
  `ASSERT_CLK(a_round_done_wait, rnd_done |-> (state_r == ST_RND_WAIT), "rounder done out of turn")
  `ASSERT_CLK(a_out_stall_hold, (state_r == ST_OUT) && out_valid_r && !out_ready |=> (state_r == ST_OUT), "result overwrote stalled word")

endmodule

`default_nettype wire

// ----- design/htu_ram.sv -----
`default_nettype none

module htu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/htu_coord.sv -----
`default_nettype none

module htu_coord #(
  parameter int STEP = htu_pkg::STEP_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         load,
  input  wire logic [htu_pkg::COORD_W-1:0]  row,
  input  wire logic [htu_pkg::COORD_W-1:0]  col,
  output logic      [htu_pkg::COORD_W-1:0]  gx,
  output logic      [htu_pkg::COORD_W-1:0]  gy,
  output logic      [$clog2(STEP)-1:0]      ox,
  output logic      [$clog2(STEP)-1:0]      oy
);

  import htu_pkg::*;

  localparam int OW = $clog2(STEP);
  localparam int PW = 2 * COORD_W;
  // Reciprocal of STEP scaled by 2^COORD_W; the estimate is low by at most one.
  localparam int CM = (1 << COORD_W) / STEP;

  logic [COORD_W-1:0] row_r, col_r, qx_r, qy_r;
  logic [PW-1:0]      px, py;
  logic [COORD_W-1:0] gx_r, gy_r;
  logic [OW-1:0]      ox_r, oy_r;
  logic [COORD_W+OW-1:0] fx, fy;

  function automatic logic [COORD_W+OW-1:0] fix_div(
    input logic [COORD_W-1:0] v,
    input logic [COORD_W-1:0] q
  );
    logic [COORD_W-1:0] rem;
    logic [COORD_W-1:0] g;
    logic [OW-1:0]      o;
    rem = COORD_W'(int'(v) - int'(q) * STEP);
    if (int'(rem) >= STEP) begin
      g = q + COORD_W'(1);
      o = OW'(int'(rem) - STEP);
    end else begin
      g = q;
      o = OW'(rem);
    end
    return {g, o};
  endfunction

  assign px = PW'(row) * PW'(CM);
  assign py = PW'(col) * PW'(CM);

  always_ff @(posedge clk) begin
    if (load) begin
      row_r <= row;
      col_r <= col;
      qx_r  <= px[PW-1:COORD_W];
      qy_r  <= py[PW-1:COORD_W];
    end
  end

  assign fx = fix_div(row_r, qx_r);
  assign fy = fix_div(col_r, qy_r);

  always_ff @(posedge clk) begin
    gx_r <= fx[COORD_W+OW-1:OW];
    ox_r <= fx[OW-1:0];
    gy_r <= fy[COORD_W+OW-1:OW];
    oy_r <= fy[OW-1:0];
  end

  assign gx = gx_r;
  assign gy = gy_r;
  assign ox = ox_r;
  assign oy = oy_r;

endmodule

`default_nettype wire

// ----- design/htu_round.sv -----
`default_nettype none

module htu_round #(
  parameter int STEP = htu_pkg::STEP_DEF
) (
  input  wire logic                                                clk,
  input  wire logic                                                rst_n,
  input  wire logic                                                load,
  input  wire logic signed [htu_pkg::SAMPLE_W+$clog2(STEP+1):0]    sum,
  output logic                                                     done,
  output logic             [htu_pkg::SAMPLE_W-1:0]                 height
);

  import htu_pkg::*;

  localparam int WW    = $clog2(STEP + 1);
  localparam int SUM_W = SAMPLE_W + 1 + WW;
  localparam int QW    = SAMPLE_W + 1;
  localparam int PW    = 2 * SUM_W;
  // The biased numerator 2*sum + STEP + 2*STEP*2^15 is never negative.
  localparam int OFS   = 2 * STEP * (1 << (SAMPLE_W - 1)) + STEP;
  localparam int RM    = (1 << SUM_W) / (2 * STEP);

  logic             v1_r, v2_r, v3_r;
  logic [SUM_W-1:0] num_r, num2_r;
  logic [QW-1:0]    q_r;
  logic [PW-1:0]    prod;
  logic [SUM_W-1:0] rem;
  logic [QW-1:0]    qf;
  logic [SAMPLE_W-1:0] height_r;

  assign prod = PW'(num_r) * PW'(RM);
  assign rem  = SUM_W'(int'(num2_r) - int'(q_r) * 2 * STEP);

  always_comb begin
    if (int'(rem) >= 2 * STEP) begin
      qf = q_r + QW'(1);
    end else begin
      qf = q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= load;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      num_r <= SUM_W'(int'(sum) * 2 + OFS);
    end
    if (v1_r) begin
      q_r    <= prod[SUM_W+QW-1:SUM_W];
      num2_r <= num_r;
    end
    if (v2_r) begin
      // Removing the bias of 2^15 from the quotient flips its top bit.
      height_r <= {~qf[SAMPLE_W-1], qf[SAMPLE_W-2:0]};
    end
  end

  assign done   = v3_r;
  assign height = height_r;

endmodule

`default_nettype wire
